// File: hw/rtl/bfs_hop_distance_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the hop distance block
// Shared property wrappers, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef BFS_HOP_DISTANCE_MACROS_SVH
`define BFS_HOP_DISTANCE_MACROS_SVH

// Check a property out of reset.
`define BHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BHD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/bhd_pkg.sv
// ---------------------------------------------------------------------------
// Hop distance package
// Field widths and status codes of the hop distance block.
// ---------------------------------------------------------------------------
package bhd_pkg;

  localparam int unsigned NODE_W = 6;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned HOP_W  = 6;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_SAME   = 3'd1;
  localparam logic [ST_W-1:0] ST_LINKED = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd3;
  localparam logic [ST_W-1:0] ST_APART  = 3'd4;

  localparam logic [HOP_W-1:0] HOPS_MAX = 6'd63;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

// File: hw/rtl/bhd_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bhd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bfs_hop_distance.sv
// ---------------------------------------------------------------------------
// Graph hop distance engine
// Stores an undirected graph as neighbor lists and answers hop distance
// queries by breadth-first search.
// ---------------------------------------------------------------------------
// Usage: an input word carries func (0 add edge, 1 query), node_a, node_b.
// A word is taken when in_valid_i is high and in_stall_o is low; every word
// gives one result word (status, hops) on the output channel.
// Operation: an add reads both degree counts and scans the neighbor list of
// a for b; if b is absent and both lists have room, it writes both neighbor
// entries and degree counts. A query pops each queued node, reads its degree
// and scans its neighbor list; one neighbor table read port, pipelined one
// entry per cycle, sets the pace of the search.
// One word is in flight at a time; in_stall_o stays high until the result
// sits in the output register. A stalled result holds and the block waits
// with the next result until the output register frees up.
// Reset empties the graph (all degree counts read as zero) and drops any
// pending result; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "bfs_hop_distance_macros.svh"

module bfs_hop_distance
  import bhd_pkg::*;
#(
  parameter int unsigned MAX_NODES  = 64,
  parameter int unsigned MAX_DEGREE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [HOP_W-1:0]  hops_o
);

  localparam int unsigned ND   = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int unsigned NAW  = $clog2(ND);
  localparam int unsigned TW   = $clog2(ND + 1);
  localparam int unsigned DGW  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned NBD  = MAX_NODES * MAX_DEGREE;
  localparam int unsigned NBAW = $clog2(NBD);
  localparam int unsigned QW   = NODE_W + HOP_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_ADD_A = 4'd2;
  localparam logic [3:0] S_ADD_B = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_WR_A  = 4'd5;
  localparam logic [3:0] S_WR_B  = 4'd6;
  localparam logic [3:0] S_POP   = 4'd7;
  localparam logic [3:0] S_QDEG  = 4'd8;
  localparam logic [3:0] S_QCNT  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]        state_q, state_d;
  logic              func_q;
  logic [NODE_W-1:0] a_q, b_q, base_q, base_d, cur_q, cur_d;
  logic [HOP_W-1:0]  hop_q, hop_d;
  logic [DGW-1:0]    deg_a_q, deg_a_d, deg_b_q, deg_b_d, cnt_q, cnt_d, idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [TW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [ND-1:0]     vis_q, vis_d, dvld_q, dvld_d;
  logic              drvld_q;
  logic [ST_W-1:0]   res_st_q, res_st_d;
  logic [HOP_W-1:0]  res_hp_q, res_hp_d;
  logic              out_vld_q;
  logic [ST_W-1:0]   out_st_q;
  logic [HOP_W-1:0]  out_hp_q;

  // memory ports
  logic              deg_we;
  logic [NAW-1:0]    deg_waddr, deg_raddr;
  logic [DGW-1:0]    deg_wdata, deg_rdata, deg_rd;
  logic              nb_we;
  logic [NBAW-1:0]   nb_waddr, nb_raddr;
  logic [NODE_W-1:0] nb_wdata, nb_rdata;
  logic              q_we;
  logic [NAW-1:0]    q_waddr, q_raddr;
  logic [QW-1:0]     q_wdata, q_rdata;

  logic              a_in, b_in, out_free;
  logic [HOP_W-1:0]  hop_nx;

  bhd_ram #(.WIDTH(DGW), .DEPTH(ND)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wdata),
    .raddr_i(deg_raddr), .rdata_o(deg_rdata)
  );

  bhd_ram #(.WIDTH(NODE_W), .DEPTH(NBD)) u_nbr (
    .clk_i, .we_i(nb_we), .waddr_i(nb_waddr), .wdata_i(nb_wdata),
    .raddr_i(nb_raddr), .rdata_o(nb_rdata)
  );

  bhd_ram #(.WIDTH(QW), .DEPTH(ND)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  // a never-written degree entry reads as zero
  assign deg_rd   = drvld_q ? deg_rdata : '0;
  assign a_in     = (32'(a_q) < 32'(MAX_NODES));
  assign b_in     = (32'(b_q) < 32'(MAX_NODES));
  assign out_free = !out_vld_q || !out_stall_i;
  assign hop_nx   = (hop_q == HOPS_MAX) ? HOPS_MAX : hop_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    cur_d     = cur_q;
    hop_d     = hop_q;
    deg_a_d   = deg_a_q;
    deg_b_d   = deg_b_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    head_d    = head_q;
    tail_d    = tail_q;
    vis_d     = vis_q;
    dvld_d    = dvld_q;
    res_st_d  = res_st_q;
    res_hp_d  = res_hp_q;
    deg_we    = 1'b0;
    deg_waddr = a_q[NAW-1:0];
    deg_wdata = deg_a_q + 1'b1;
    deg_raddr = a_q[NAW-1:0];
    nb_we     = 1'b0;
    nb_waddr  = NBAW'(32'(a_q) * 32'(MAX_DEGREE) + 32'(deg_a_q));
    nb_wdata  = b_q;
    nb_raddr  = NBAW'(32'(base_q) * 32'(MAX_DEGREE) + 32'(idx_q));
    q_we      = 1'b0;
    q_waddr   = tail_q[NAW-1:0];
    q_wdata   = {nb_rdata, hop_nx};
    q_raddr   = head_q[NAW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        res_hp_d = '0;
        if (func_q == FUNC_ADD) begin
          if (a_q == b_q) begin
            res_st_d = ST_SAME;
            state_d  = S_DONE;
          end else if (!a_in || !b_in) begin
            res_st_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            state_d = S_ADD_A;
          end
        end else begin
          if (!a_in || !b_in) begin
            res_st_d = ST_APART;
            state_d  = S_DONE;
          end else if (a_q == b_q) begin
            res_st_d = ST_OK;
            state_d  = S_DONE;
          end else begin
            vis_d                 = '0;
            vis_d[a_q[NAW-1:0]]   = 1'b1;
            q_we                  = 1'b1;
            q_waddr               = '0;
            q_wdata               = {a_q, {HOP_W{1'b0}}};
            head_d                = '0;
            tail_d                = TW'(1);
            state_d               = S_POP;
          end
        end
      end
      S_ADD_A: begin
        deg_a_d   = deg_rd;
        deg_raddr = b_q[NAW-1:0];
        state_d   = S_ADD_B;
      end
      S_ADD_B: begin
        deg_b_d = deg_rd;
        cnt_d   = deg_a_q;
        base_d  = a_q;
        idx_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // issue one read per cycle, compare the word read last cycle
        if (idx_q < cnt_q) begin
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          if (func_q == FUNC_ADD) begin
            if (nb_rdata == b_q) begin
              res_st_d = ST_LINKED;
              state_d  = S_DONE;
            end
          end else if (!vis_q[nb_rdata[NAW-1:0]]) begin
            vis_d[nb_rdata[NAW-1:0]] = 1'b1;
            if (tail_q < TW'(ND)) begin
              q_we   = 1'b1;
              tail_d = tail_q + 1'b1;
            end
            if (nb_rdata == b_q) begin
              res_st_d = ST_OK;
              res_hp_d = hop_nx;
              state_d  = S_DONE;
            end
          end
        end else if (idx_q == cnt_q) begin
          if (func_q == FUNC_QUERY) begin
            state_d = S_POP;
          end else if (deg_a_q == DGW'(MAX_DEGREE) || deg_b_q == DGW'(MAX_DEGREE)) begin
            res_st_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            state_d = S_WR_A;
          end
        end
      end
      S_WR_A: begin
        nb_we                 = 1'b1;
        deg_we                = 1'b1;
        dvld_d[a_q[NAW-1:0]]  = 1'b1;
        state_d               = S_WR_B;
      end
      S_WR_B: begin
        nb_we                 = 1'b1;
        nb_waddr              = NBAW'(32'(b_q) * 32'(MAX_DEGREE) + 32'(deg_b_q));
        nb_wdata              = a_q;
        deg_we                = 1'b1;
        deg_waddr             = b_q[NAW-1:0];
        deg_wdata             = deg_b_q + 1'b1;
        dvld_d[b_q[NAW-1:0]]  = 1'b1;
        res_st_d              = ST_OK;
        state_d               = S_DONE;
      end
      S_POP: begin
        if (head_q == tail_q) begin
          res_st_d = ST_APART;
          state_d  = S_DONE;
        end else begin
          head_d  = head_q + 1'b1;
          state_d = S_QDEG;
        end
      end
      S_QDEG: begin
        cur_d     = q_rdata[QW-1:HOP_W];
        hop_d     = q_rdata[HOP_W-1:0];
        deg_raddr = q_rdata[HOP_W+NAW-1:HOP_W];
        state_d   = S_QCNT;
      end
      S_QCNT: begin
        cnt_d   = deg_rd;
        base_d  = cur_q;
        idx_d   = '0;
        state_d = S_SCAN;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pend_q    <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      vis_q     <= '0;
      dvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      vis_q   <= vis_d;
      dvld_q  <= dvld_d;
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      func_q <= func_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
    end
    if (state_q == S_DONE && out_free) begin
      out_st_q <= res_st_q;
      out_hp_q <= res_hp_q;
    end
    drvld_q  <= dvld_q[deg_raddr];
    base_q   <= base_d;
    cur_q    <= cur_d;
    hop_q    <= hop_d;
    deg_a_q  <= deg_a_d;
    deg_b_q  <= deg_b_d;
    cnt_q    <= cnt_d;
    idx_q    <= idx_d;
    res_st_q <= res_st_d;
    res_hp_q <= res_hp_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign status_o    = out_st_q;
  assign hops_o      = out_hp_q;

  `BHD_ASSERT(a_queue_bound, tail_q <= TW'(ND), "queue tail beyond depth")
  `BHD_ASSERT(a_head_tail, head_q <= tail_q, "queue head passed tail")
  `BHD_ASSERT(a_scan_idx, state_q == S_SCAN |-> idx_q <= cnt_q, "scan index past degree")
  `BHD_ASSERT(a_hops_ok, out_valid_o && status_o != ST_OK |-> hops_o == '0, "hops on failure")
  `BHD_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Hop distance block testbench
// Feeds add-edge and hop-distance query words with random gaps and
// output stalls, predicts each result from a local copy of the graph and
// checks the result words in order.
// ---------------------------------------------------------------------------
module tb_top;
  import bhd_pkg::*;

  localparam int unsigned NODES     = 64;
  localparam int unsigned DEGREE    = 16;
  localparam int unsigned IDLE_MAX  = 20000;

  typedef struct packed {
    logic              func;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } graph_op_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [HOP_W-1:0] hops;
  } hop_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              func_i = 1'b0;
  logic [NODE_W-1:0] node_a_i = '0;
  logic [NODE_W-1:0] node_b_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ST_W-1:0]   status_o;
  logic [HOP_W-1:0]  hops_o;

  bfs_hop_distance u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .node_a_i, .node_b_i,
    .out_valid_o, .out_stall_i, .status_o, .hops_o
  );

  always #4 clk_i = ~clk_i;

  graph_op_t   pending_ops[$];
  hop_result_t expected_results[$];
  int unsigned fail_count = 0;
  int unsigned words_taken = 0;
  bit          word_taken = 1'b0;

  // Local graph copy
  logic [NODE_W-1:0] adj[NODES][DEGREE];
  int unsigned       deg[NODES];

  function automatic bit linked(int unsigned a, int unsigned b);
    for (int unsigned i = 0; i < deg[a]; i++)
      if (adj[a][i] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic hop_result_t apply_op(graph_op_t op);
    hop_result_t       r;
    bit                seen[NODES];
    int unsigned       hop_cnt[NODES];
    int unsigned       order[NODES];
    int unsigned       head, tail, cur, nb;
    r = '0;
    if (op.func == FUNC_ADD) begin
      if (op.a == op.b) r.status = ST_SAME;
      else if (linked(op.a, op.b)) r.status = ST_LINKED;
      else if (deg[op.a] >= DEGREE || deg[op.b] >= DEGREE) r.status = ST_FULL;
      else begin
        adj[op.a][deg[op.a]] = op.b;
        deg[op.a]++;
        adj[op.b][deg[op.b]] = op.a;
        deg[op.b]++;
        r.status = ST_OK;
      end
      return r;
    end
    if (op.a == op.b) return r;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[op.a] = 1'b1;
    hop_cnt[op.a] = 0;
    order[0] = op.a;
    head = 0;
    tail = 1;
    while (head < tail) begin
      cur = order[head];
      head++;
      for (int unsigned i = 0; i < deg[cur]; i++) begin
        nb = adj[cur][i];
        if (!seen[nb]) begin
          seen[nb] = 1'b1;
          hop_cnt[nb] = (hop_cnt[cur] < 32'(HOPS_MAX)) ? hop_cnt[cur] + 1 : 32'(HOPS_MAX);
          if (tail < NODES) begin
            order[tail] = nb;
            tail++;
          end
          if (nb == op.b) begin
            r.status = ST_OK;
            r.hops = HOP_W'(hop_cnt[nb]);
            return r;
          end
        end
      end
    end
    r.status = ST_APART;
    return r;
  endfunction

  function automatic graph_op_t mk(logic f, int unsigned a, int unsigned b);
    graph_op_t op;
    op.func = f;
    op.a = NODE_W'(a);
    op.b = NODE_W'(b);
    return op;
  endfunction

  function automatic void queue_op(graph_op_t op);
    pending_ops = {pending_ops, op};
  endfunction

  // Accept input words and predict their results
  always @(posedge clk_i) begin
    word_taken <= 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results = {expected_results, apply_op(mk(func_i, node_a_i, node_b_i))};
      word_taken <= 1'b1;
      words_taken++;
    end
  end

  // Driver: bursts of words separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk_i) begin
    graph_op_t op;
    if (rst_ni && !(in_valid_i && !word_taken)) begin
      if (gap_left > 0 || pending_ops.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        op = pending_ops.pop_front();
        in_valid_i <= 1'b1;
        func_i <= op.func;
        node_a_i <= op.a;
        node_b_i <= op.b;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off to back up the input
  int unsigned stall_left = 0;
  bit          held_off = 1'b0;
  int unsigned stall_mode = 0;
  always @(negedge clk_i) begin
    if (!held_off && words_taken >= 300) begin
      held_off = 1'b1;
      stall_left = 3000;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        default: begin
          out_stall_i <= 1'b0;
          if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 40);
        end
      endcase
    end
  end

  // Monitor: compare result words against predictions in order
  always @(posedge clk_i) begin
    hop_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: status %0d hops %0d",
               status_o, hops_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (hops_o !== want.hops) begin
          $error("hops: expected %0d, got %0d", want.hops, hops_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    foreach (deg[i]) deg[i] = 0;
    // Directed: self edge, duplicate, full list, same-node and unreachable queries
    queue_op(mk(FUNC_ADD, 5, 5));
    queue_op(mk(FUNC_ADD, 0, 1));
    queue_op(mk(FUNC_ADD, 1, 0));
    for (int i = 2; i <= 16; i++) queue_op(mk(FUNC_ADD, 0, i));
    queue_op(mk(FUNC_ADD, 0, 17));
    queue_op(mk(FUNC_ADD, 63, 0));
    queue_op(mk(FUNC_QUERY, 0, 0));
    queue_op(mk(FUNC_QUERY, 0, 1));
    queue_op(mk(FUNC_QUERY, 2, 3));
    queue_op(mk(FUNC_QUERY, 0, 63));
    queue_op(mk(FUNC_ADD, 63, 62));
    queue_op(mk(FUNC_QUERY, 62, 63));
    // Long chain for deep searches
    queue_op(mk(FUNC_ADD, 16, 17));
    for (int i = 17; i < 63; i++) queue_op(mk(FUNC_ADD, i, i + 1));
    queue_op(mk(FUNC_QUERY, 1, 63));
    queue_op(mk(FUNC_QUERY, 63, 2));
    // Random mix; adds and queries are equally likely
    for (int i = 0; i < 1050; i++) begin
      if ($urandom_range(0, 1) == 0)
        queue_op(mk(FUNC_ADD, $urandom_range(0, 63),
                    ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, 63)));
      else
        queue_op(mk(FUNC_QUERY, $urandom_range(0, 63),
                    ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(0, 63)));
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_ops.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
